@@ rtl/fpau_pkg.sv @@
// Package for the fixed-point arithmetic unit: word sizes, codes, queue and stage types.
// Also holds the shared one-bit divide and square-root step function.
// Depends on nothing.
package fpau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;
  localparam int RAD_BITS  = 2 * ((DIV_STEPS + 1) / 2);
  localparam int SQ_STEPS  = RAD_BITS / 2;
  localparam int PROD_BITS = 2 * WORD_BITS - FRAC_BITS;
  localparam int MAG_A     = (PROD_BITS > DIV_STEPS) ? PROD_BITS : DIV_STEPS;
  localparam int MAG_BITS  = (MAG_A > WORD_BITS + 1) ? MAG_A : WORD_BITS + 1;
  localparam int LATENCY   = DIV_STEPS + 3;

  localparam logic [MAG_BITS-1:0] MIN_MAG = MAG_BITS'(1) << (WORD_BITS - 1);

  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADOP   = 3'd1;
  localparam logic [2:0] ST_DIVZERO = 3'd2;
  localparam logic [2:0] ST_NEGROOT = 3'd3;
  localparam logic [2:0] ST_SAT     = 3'd4;

  typedef enum logic [1:0] {K_ADD, K_MUL, K_DIV, K_SQRT} kind_t;

  typedef struct packed {
    kind_t                kind;
    logic                 na;
    logic [WORD_BITS-1:0] ma;
    logic                 nb;
    logic [WORD_BITS-1:0] mb;
    logic [2:0]           err;
  } item_t;

  typedef struct packed {
    kind_t                kind;
    logic                 neg;
    logic [2:0]           err;
    logic [DIV_STEPS-1:0] div_num;
    logic [WORD_BITS-1:0] div_rem;
    logic [WORD_BITS-1:0] divisor;
    logic [RAD_BITS-1:0]  sq_rad;
    logic [SQ_STEPS+1:0]  sq_rem;
    logic [SQ_STEPS-1:0]  sq_root;
    logic [MAG_BITS-1:0]  wide;
  } stage_t;

  function automatic stage_t stage_step(input stage_t s, input logic sq_en);
    stage_t               r;
    logic [WORD_BITS:0]   rem_sh;
    logic                 dge;
    logic [SQ_STEPS+3:0]  sr_sh;
    logic [SQ_STEPS+3:0]  trial;
    logic                 sge;
    r      = s;
    rem_sh = {s.div_rem, s.div_num[DIV_STEPS-1]};
    dge    = rem_sh >= {1'b0, s.divisor};
    r.div_rem = dge ? WORD_BITS'(rem_sh - {1'b0, s.divisor}) : rem_sh[WORD_BITS-1:0];
    r.div_num = {s.div_num[DIV_STEPS-2:0], dge};
    if (sq_en) begin
      sr_sh = {s.sq_rem, s.sq_rad[RAD_BITS-1 -: 2]};
      trial = {2'b00, s.sq_root, 2'b01};
      sge   = sr_sh >= trial;
      r.sq_rem  = sge ? (SQ_STEPS+2)'(sr_sh - trial) : sr_sh[SQ_STEPS+1:0];
      r.sq_rad  = {s.sq_rad[RAD_BITS-3:0], 2'b00};
      r.sq_root = {s.sq_root[SQ_STEPS-2:0], sge};
    end
    return r;
  endfunction

endpackage

@@ rtl/fixed_point_arith_unit.sv @@
// Top level of the fixed-point arithmetic unit: front end, queue and execution pipeline.
// Depends on fpau_pkg, fpau_front, fpau_queue and fpau_back.
//
// Usage: present op, operand_a and operand_b (signed Q16.16) with start high; the word is
// taken at a rising edge where start is high and busy is low. Opcodes: 1 add, 2 subtract,
// 3 multiply, 4 divide, 5 square root; others give status 1 and value 0.
// Each accepted word yields exactly one result, shown on value and status for one cycle
// with done high. Each result passes through the queue and then through the Q16.16
// divider, which resolves one quotient bit per pipeline stage; the root uses the first
// half of the same stages. One word is accepted every cycle while busy is low.
// The receiver cannot stall; the execution pipeline advances every cycle, so the queue
// never fills and busy stays low in operation.
// Reset clears the queue and all valid bits; no results are produced until new words.
module fixed_point_arith_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           op,
  input  logic signed [fpau_pkg::WORD_BITS-1:0] operand_a,
  input  logic signed [fpau_pkg::WORD_BITS-1:0] operand_b,
  output logic                                 done,
  output logic signed [fpau_pkg::WORD_BITS-1:0] value,
  output logic [2:0]                           status
);
  import fpau_pkg::*;

  logic  push, q_valid;
  item_t wr_item, rd_item;
  logic [WORD_BITS-1:0] value_u;

  fpau_front u_front (
    .start(start), .full(busy), .op(op), .operand_a(operand_a), .operand_b(operand_b),
    .push(push), .item(wr_item)
  );

  fpau_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_item(wr_item), .pop(q_valid),
    .q_valid(q_valid), .full(busy), .rd_item(rd_item)
  );

  fpau_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(rd_item),
    .done(done), .value(value_u), .status(status)
  );

  assign value = signed'(value_u);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(LATENCY) done)
    else $error("result did not appear at the expected latency");
  a_never_full: assert property (@(posedge clk) disable iff (rst)
    q_valid |=> !busy)
    else $error("queue filled although the pipeline drains every cycle");
endmodule

@@ rtl/fpau_front.sv @@
// Front end of the fixed-point unit: splits operands into sign and magnitude and classifies
// the opcode and error cases into one queue word. Depends on fpau_pkg.
module fpau_front (
  input  logic                          start,
  input  logic                          full,
  input  logic [2:0]                    op,
  input  logic [fpau_pkg::WORD_BITS-1:0] operand_a,
  input  logic [fpau_pkg::WORD_BITS-1:0] operand_b,
  output logic                          push,
  output fpau_pkg::item_t               item
);
  import fpau_pkg::*;

  logic na, nb;
  logic [WORD_BITS-1:0] ma, mb;

  assign na = operand_a[WORD_BITS-1];
  assign nb = operand_b[WORD_BITS-1];
  assign ma = na ? WORD_BITS'(~operand_a + 1'b1) : operand_a;
  assign mb = nb ? WORD_BITS'(~operand_b + 1'b1) : operand_b;
  assign push = start && !full;

  always_comb begin
    item.na   = na;
    item.ma   = ma;
    item.nb   = nb;
    item.mb   = mb;
    item.kind = K_ADD;
    item.err  = ST_OK;
    unique case (op)
      OP_ADD: item.kind = K_ADD;
      OP_SUB: begin
        item.kind = K_ADD;
        item.nb   = !nb;
      end
      OP_MUL: item.kind = K_MUL;
      OP_DIV: begin
        item.kind = K_DIV;
        if (mb == '0) item.err = ST_DIVZERO;
      end
      OP_SQRT: begin
        item.kind = K_SQRT;
        if (na) item.err = ST_NEGROOT;
      end
      default: item.err = ST_BADOP;
    endcase
  end
endmodule

@@ rtl/fpau_queue.sv @@
// Two-word queue between the front end and the execution pipeline.
// Depends on fpau_pkg.
module fpau_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fpau_pkg::item_t wr_item,
  input  logic            pop,
  output logic            q_valid,
  output logic            full,
  output fpau_pkg::item_t rd_item
);
  import fpau_pkg::*;

  item_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign q_valid = count != 2'd0;
  assign full    = count == 2'd2;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_item;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop && q_valid) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop && q_valid);
    end
  end
endmodule

@@ rtl/fpau_back.sv @@
// Execution pipeline: add and multiply at entry, one divide bit per stage, one root bit in
// the first SQ_STEPS stages, then saturation and output packing. Depends on fpau_pkg.
module fpau_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  fpau_pkg::item_t               q_item,
  output logic                          done,
  output logic [fpau_pkg::WORD_BITS-1:0] value,
  output logic [2:0]                    status
);
  import fpau_pkg::*;

  stage_t st [0:DIV_STEPS];
  logic   vld [0:DIV_STEPS];
  stage_t load;
  logic [WORD_BITS:0]     sum;
  logic [2*WORD_BITS-1:0] prod;
  logic [MAG_BITS-1:0]    mag, lim, mag_sat;
  logic [2:0]             st_next;
  stage_t last;

  assign sum  = {1'b0, q_item.ma} + {1'b0, q_item.mb};
  assign prod = q_item.ma * q_item.mb;

  always_comb begin
    load         = '0;
    load.kind    = q_item.kind;
    load.err     = q_item.err;
    load.neg     = q_item.na ^ q_item.nb;
    load.divisor = q_item.mb;
    load.div_num = DIV_STEPS'({q_item.ma, {FRAC_BITS{1'b0}}});
    load.sq_rad  = RAD_BITS'({q_item.ma, {FRAC_BITS{1'b0}}});
    case (q_item.kind)
      K_ADD: begin
        if (q_item.na == q_item.nb) begin
          load.neg  = q_item.na;
          load.wide = MAG_BITS'(sum);
        end else if (q_item.ma >= q_item.mb) begin
          load.neg  = q_item.na;
          load.wide = MAG_BITS'(q_item.ma - q_item.mb);
        end else begin
          load.neg  = q_item.nb;
          load.wide = MAG_BITS'(q_item.mb - q_item.ma);
        end
      end
      K_MUL:  load.wide = MAG_BITS'(prod[2*WORD_BITS-1:FRAC_BITS]);
      K_SQRT: load.neg  = 1'b0;
      default: ;
    endcase
  end

  assign last = st[DIV_STEPS];

  always_comb begin
    case (last.kind)
      K_DIV:   mag = MAG_BITS'(last.div_num);
      K_SQRT:  mag = MAG_BITS'(last.sq_root);
      default: mag = last.wide;
    endcase
    lim     = last.neg ? MIN_MAG : MIN_MAG - 1'b1;
    mag_sat = mag;
    st_next = last.err;
    if (last.err != ST_OK) begin
      mag_sat = '0;
    end else if (mag > lim) begin
      mag_sat = lim;
      st_next = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= load;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      st[k] <= stage_step(st[k-1], k <= SQ_STEPS);
    end
    value  <= last.neg ? WORD_BITS'(~mag_sat + 1'b1) : mag_sat[WORD_BITS-1:0];
    status <= st_next;
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) vld[k] <= 1'b0;
      done <= 1'b0;
    end else begin
      vld[0] <= q_valid;
      for (int k = 1; k <= DIV_STEPS; k++) vld[k] <= vld[k-1];
      done <= vld[DIV_STEPS];
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK && status != ST_SAT |-> value == '0)
    else $error("error result carries a nonzero value");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= ST_SAT)
    else $error("status code out of range");
endmodule

@@ test/fpau_checker.sv @@
// Checker for the fixed-point arithmetic unit: predicts each result from accepted words.
// Compares value and status in order of acceptance. Depends on fpau_pkg.
module fpau_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic [2:0]                             op,
  input  logic signed [fpau_pkg::WORD_BITS-1:0]  operand_a,
  input  logic signed [fpau_pkg::WORD_BITS-1:0]  operand_b,
  input  logic                                   done,
  input  logic signed [fpau_pkg::WORD_BITS-1:0]  value,
  input  logic [2:0]                             status,
  output int                                     fail_count,
  output int                                     pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpau_pkg::*;

  typedef struct packed {
    logic [WORD_BITS-1:0] val;
    logic [2:0]           st;
  } result_t;

  result_t expected_q[$];

  function automatic result_t saturate(input logic neg, input logic [127:0] mag);
    result_t r;
    logic [127:0] lim;
    lim = neg ? 128'(MIN_MAG) : 128'(MIN_MAG) - 1;
    r.st = ST_OK;
    if (mag > lim) begin
      mag = lim;
      r.st = ST_SAT;
    end
    r.val = neg ? WORD_BITS'(-mag) : WORD_BITS'(mag);
    return r;
  endfunction

  function automatic result_t compute(input logic [2:0] code, input logic [WORD_BITS-1:0] a,
                                      input logic [WORD_BITS-1:0] b);
    result_t r;
    logic na, nb;
    logic [127:0] ma, mb, t, root;
    logic signed [129:0] sa, sb, s;
    na = a[WORD_BITS-1];
    nb = b[WORD_BITS-1];
    ma = na ? 128'(WORD_BITS'(-a)) : 128'(a);
    mb = nb ? 128'(WORD_BITS'(-b)) : 128'(b);
    if (na && ma == 0) ma = 128'(MIN_MAG);
    if (nb && mb == 0) mb = 128'(MIN_MAG);
    sa = na ? -$signed({2'b00, ma}) : $signed({2'b00, ma});
    sb = nb ? -$signed({2'b00, mb}) : $signed({2'b00, mb});
    r = '0;
    case (code) inside
      OP_ADD, OP_SUB: begin
        s = (code == OP_ADD) ? sa + sb : sa - sb;
        r = saturate(s < 0, s < 0 ? 128'(-s) : 128'(s));
      end
      OP_MUL: r = saturate(na != nb, (ma * mb) >> FRAC_BITS);
      OP_DIV: begin
        if (mb == 0) r.st = ST_DIVZERO;
        else r = saturate(na != nb, (ma << FRAC_BITS) / mb);
      end
      OP_SQRT: begin
        if (na) r.st = ST_NEGROOT;
        else begin
          t = ma << FRAC_BITS;
          root = 0;
          for (int i = 63; i >= 0; i--)
            if (((root | (128'(1) << i)) * (root | (128'(1) << i))) <= t)
              root = root | (128'(1) << i);
          r = saturate(1'b0, root);
        end
      end
      default: r.st = ST_BADOP;
    endcase
    return r;
  endfunction

  assign pending = expected_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected result value=%h status=%0d", value, status);
        end else begin
          want = expected_q.pop_front();
          if (want.val !== value || want.st !== status) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("Mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                       want.val, want.st, value, status);
          end
        end
      end
      if (start && !busy) expected_q.push_back(compute(op, operand_a, operand_b));
    end
  end
endmodule

@@ test/tb_top.sv @@
// Testbench top for the fixed-point arithmetic unit: drives directed and random words.
// Depends on fpau_pkg, fpau_checker and the unit itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fpau_pkg::*;

  logic clk = 0, rst = 1, start = 0;
  logic [2:0] op = 0;
  logic signed [WORD_BITS-1:0] operand_a = 0, operand_b = 0;
  logic busy, done;
  logic signed [WORD_BITS-1:0] value;
  logic [2:0] status;
  int fail_count, pending;
  int cycles = 0;

  localparam logic [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] ONE  = 1 << FRAC_BITS;

  always #10 clk = ~clk;

  fixed_point_arith_unit uut (.*);

  fpau_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("fixed_point_arith_unit test failed");
      $finish;
    end
  end

  task automatic send_word(input logic [2:0] code, input logic [WORD_BITS-1:0] a,
                           input logic [WORD_BITS-1:0] b, input bit quiet);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    start <= 1;
    op <= code;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [WORD_BITS-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return MAXV;
      1: return MINV;
      2: return $urandom_range(0, 3) * ONE - ONE;
      3: return WORD_BITS'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [2:0] code;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_word(OP_ADD, MAXV, ONE, 0);
    send_word(OP_ADD, MINV, MINV, 0);
    send_word(OP_SUB, MINV, ONE, 0);
    send_word(OP_SUB, 0, MINV, 0);
    send_word(OP_MUL, MAXV, MAXV, 0);
    send_word(OP_MUL, MINV, MINV, 0);
    send_word(OP_MUL, MINV, ONE, 0);
    send_word(OP_MUL, 3 * ONE, -2 * ONE, 0);
    send_word(OP_DIV, ONE, 0, 0);
    send_word(OP_DIV, MINV, -1, 0);
    send_word(OP_DIV, MAXV, 1, 0);
    send_word(OP_DIV, -7 * ONE, 2 * ONE, 0);
    send_word(OP_SQRT, 0, MAXV, 0);
    send_word(OP_SQRT, -1, 0, 0);
    send_word(OP_SQRT, MINV, 0, 0);
    send_word(OP_SQRT, MAXV, 0, 0);
    send_word(OP_SQRT, 2 * ONE, 0, 0);
    send_word(3'd0, ONE, ONE, 0);
    send_word(3'd6, MAXV, MINV, 0);
    send_word(3'd7, -1, -1, 0);
    for (int i = 0; i < 400; i++) begin
      code = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 5));
      send_word(code, rand_operand(), ($urandom_range(0, 15) == 0) ? '0 : rand_operand(),
                i >= 340);
    end
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("fixed_point_arith_unit test passed");
    else $display("fixed_point_arith_unit test failed");
    $finish;
  end
endmodule
